>>> rtl/assert_macros.svh
// Assertion macros included by the hash map core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/gthm_pkg.sv
// ----------------------------------------------------------------------------
// gthm_pkg
// Types and constants of the grouped tag hash map.
// ----------------------------------------------------------------------------
package gthm_pkg;

  localparam int unsigned GroupCount  = 64;
  localparam int unsigned GroupSize   = 16;
  localparam int unsigned MaxProbes   = 64;
  localparam int unsigned TargetWidth = 16;

  localparam int unsigned GroupW = (GroupCount > 1) ? $clog2(GroupCount) : 1;
  localparam int unsigned ProbeW = $clog2(MaxProbes + 1);

  localparam logic [7:0] MetaEmpty   = 8'h01;
  localparam logic [7:0] MetaDead    = 8'h02;
  localparam logic [7:0] MetaTagMask = 8'hFC;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef struct packed {
    logic        opcode;
    logic [63:0] key_hash;
    logic [15:0] target_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] target_out;
  } out_item_t;

  // One group row of every store.
  typedef logic [GroupSize-1:0][7:0]             meta_row_t;
  typedef logic [GroupSize-1:0][63:0]            hash_row_t;
  typedef logic [GroupSize-1:0][TargetWidth-1:0] tgt_row_t;

  // Result of scanning one group.
  typedef struct packed {
    logic                         hit;
    logic [$clog2(GroupSize)-1:0] hit_lane;
    logic                         has_empty;
    logic [$clog2(GroupSize)-1:0] empty_lane;
    logic                         has_dead;
    logic [$clog2(GroupSize)-1:0] dead_lane;
  } scan_t;

endpackage

>>> rtl/gthm_scan.sv
// ----------------------------------------------------------------------------
// gthm_scan
// Registered lane scan of one group: first match, first empty, first dead.
// ----------------------------------------------------------------------------
module gthm_scan
  import gthm_pkg::*;
(
  input  logic        clk_i,
  input  logic [63:0] key_hash_i,
  input  meta_row_t   meta_i,
  input  hash_row_t   hash_i,
  output scan_t       scan_o
);

  localparam int unsigned LaneW = $clog2(GroupSize);

  scan_t scan_d, scan_q;
  logic [7:0] tag;

  assign tag = key_hash_i[7:0] & MetaTagMask;

  always_comb begin
    scan_d = '0;
    for (int i = GroupSize - 1; i >= 0; i--) begin
      if (meta_i[i] == tag && hash_i[i] == key_hash_i) begin
        scan_d.hit      = 1'b1;
        scan_d.hit_lane = LaneW'(i);
      end
      if (meta_i[i] == MetaEmpty) begin
        scan_d.has_empty  = 1'b1;
        scan_d.empty_lane = LaneW'(i);
      end
      if (meta_i[i] == MetaDead) begin
        scan_d.has_dead  = 1'b1;
        scan_d.dead_lane = LaneW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
  end

  assign scan_o = scan_q;

endmodule

>>> rtl/grouped_tag_hash_map_core.sv
// ----------------------------------------------------------------------------
// grouped_tag_hash_map_core
// Swiss-table style hash map: groups of 16 slots kept in row-wide memories.
// ----------------------------------------------------------------------------
// Sequence: each probed group passes through the read, scan and decide states in
//   the find search; a set without a duplicate then repeats them for each group
//   of the insert search, and the done state presents the result.
// Flow: one item at a time; the next item is accepted once the result is loaded
//   into the output register.
// Reset: a clearing pass writes every metadata row to empty; no item is
//   accepted until it ends.
module grouped_tag_hash_map_core
  import gthm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

`include "assert_macros.svh"

  localparam int unsigned LaneW = $clog2(GroupSize);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_EVAL  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Row-wide memories: one group per address.
  meta_row_t meta_mem [GroupCount];
  hash_row_t hash_mem [GroupCount];
  tgt_row_t  tgt_mem  [GroupCount];
  meta_row_t meta_rd_q;
  hash_row_t hash_rd_q;
  tgt_row_t  tgt_rd_q;

  in_item_t           item_q, item_d;
  logic [GroupW-1:0]  grp_q, grp_d;
  logic [ProbeW-1:0]  probe_q, probe_d;     // groups probed so far
  logic [GroupW-1:0]  step_q, step_d;       // probe count squared mod groups
  logic [GroupW-1:0]  odd_q, odd_d;         // next odd increment mod groups
  logic               ins_q, ins_d;         // set phase: insert search
  logic [GroupW-1:0]  clr_q, clr_d;
  out_item_t          res_q, res_d;         // result of the item in flight
  out_item_t          out_q, out_d;
  logic               out_vld_q, out_vld_d;

  logic              wr_en;
  logic [GroupW-1:0] wr_addr;
  logic [LaneW-1:0]  wr_lane;
  logic              clr_en;
  scan_t             scan;
  logic              last_probe;

  function automatic logic [GroupW-1:0] add_mod(logic [GroupW-1:0] a,
                                                logic [GroupW-1:0] b);
    logic [GroupW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (GroupW+1)'(GroupCount)) s = s - (GroupW+1)'(GroupCount);
    return s[GroupW-1:0];
  endfunction

  gthm_scan u_scan (
    .clk_i      (clk_i),
    .key_hash_i (item_q.key_hash),
    .meta_i     (meta_rd_q),
    .hash_i     (hash_rd_q),
    .scan_o     (scan)
  );

  assign last_probe = (probe_q == ProbeW'(MaxProbes - 1));

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    grp_d     = grp_q;
    probe_d   = probe_q;
    step_d    = step_q;
    odd_d     = odd_q;
    ins_d     = ins_q;
    clr_d     = clr_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    wr_en     = 1'b0;
    wr_lane   = '0;
    clr_en    = 1'b0;
    if (out_vld_q && out_ready_i) out_vld_d = 1'b0;
    case (state_q)
      S_CLEAR: begin
        clr_en = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == GroupW'(GroupCount - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        // Accept an item; start the probe at the home group.
        if (in_valid_i && in_ready_o) begin
          item_d  = in_item_i;
          grp_d   = GroupW'(in_item_i.key_hash % GroupCount);
          probe_d = '0;
          step_d  = '0;
          odd_d   = GroupW'(1 % GroupCount);
          ins_d   = 1'b0;
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_SCAN;   // memory read in flight
      S_SCAN: state_d = S_EVAL;   // lane scan registered
      S_EVAL: begin
        state_d = S_DONE;
        res_d   = '0;
        if (!ins_q) begin
          if (scan.hit) begin
            res_d.status = item_q.opcode ? ST_DUPLICATE : ST_FOUND;
            if (!item_q.opcode) res_d.target_out = 16'(tgt_rd_q[scan.hit_lane]);
          end else if (scan.has_empty || last_probe) begin
            if (!item_q.opcode) begin
              res_d.status = ST_NOT_FOUND;
            end else begin
              // Restart at the home group for the insert search.
              ins_d   = 1'b1;
              grp_d   = GroupW'(item_q.key_hash % GroupCount);
              probe_d = '0;
              step_d  = '0;
              odd_d   = GroupW'(1 % GroupCount);
              state_d = S_READ;
            end
          end else begin
            state_d = S_READ;
          end
        end else if (scan.has_empty || scan.has_dead) begin
          wr_en        = 1'b1;
          wr_lane      = scan.has_empty ? scan.empty_lane : scan.dead_lane;
          res_d.status = ST_INSERTED;
        end else if (last_probe) begin
          res_d.status = ST_FULL;
        end else begin
          state_d = S_READ;
        end
        if (state_d == S_READ && !(ins_d && !ins_q)) begin
          // Advance quadratically: step += 2k+1, group += step.
          probe_d = probe_q + 1'b1;
          step_d  = add_mod(step_q, odd_q);
          odd_d   = add_mod(odd_q, GroupW'(2 % GroupCount));
          grp_d   = add_mod(grp_q, add_mod(step_q, odd_q));
        end
      end
      S_DONE: begin
        // Hold the result until the output register is free.
        if (!out_vld_d) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  assign wr_addr     = clr_en ? clr_q : grp_q;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (clr_en) begin
      meta_mem[wr_addr] <= {GroupSize{MetaEmpty}};
    end else if (wr_en) begin
      meta_mem[wr_addr][wr_lane] <= item_q.key_hash[7:0] & MetaTagMask;
      hash_mem[wr_addr][wr_lane] <= item_q.key_hash;
      tgt_mem[wr_addr][wr_lane]  <= item_q.target_in[TargetWidth-1:0];
    end
    meta_rd_q <= meta_mem[grp_d];
    hash_rd_q <= hash_mem[grp_d];
    tgt_rd_q  <= tgt_mem[grp_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
      probe_q   <= '0;
      ins_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
      probe_q   <= probe_d;
      ins_q     <= ins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    grp_q  <= grp_d;
    step_q <= step_d;
    odd_q  <= odd_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  `ASSERT_NEVER(a_probe_cap, clk_i, rst_ni, probe_q > ProbeW'(MaxProbes - 1), "probe over cap")
  `ASSERT_NEVER(a_no_write_clear, clk_i, rst_ni, wr_en && clr_en, "write during clear")
  `ASSERT_PROP(a_result_after_eval, clk_i, rst_ni, (state_q == S_EVAL && state_d == S_DONE) |=> res_q.status <= ST_FULL, "bad status")
  `ASSERT_NEVER(a_found_only_find, clk_i, rst_ni, state_q == S_DONE && res_q.status == ST_FOUND && item_q.opcode, "found on set")

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the grouped tag hash map core. It drives find and set items
// through the valid/ready input channel and keeps its own copy of the
// metadata, hash and target stores. For each accepted item it works out the
// expected status and target. It checks every result item in order and
// fails on any mismatch, on a result with nothing expected and on a timeout.
// ----------------------------------------------------------------------------
module tb_top;
  import gthm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SlotTotal = GroupCount * GroupSize;
  localparam int unsigned RandItems = 600;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  grouped_tag_hash_map_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the table.
  logic [7:0]             shadow_meta [SlotTotal];
  logic [63:0]            shadow_hash [SlotTotal];
  logic [TargetWidth-1:0] shadow_tgt  [SlotTotal];

  out_item_t   pending_results[$];
  logic [63:0] stored_keys[$];
  int unsigned mismatch_count = 0;
  int unsigned result_count   = 0;
  int unsigned full_count     = 0;
  int unsigned found_count    = 0;
  bit          idle_enable    = 1'b1;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Search the shadow table; return the slot of the key, or -1.
  function automatic int locate_key(input logic [63:0] key);
    logic [7:0]  tag;
    int unsigned grp;
    bit          seen_empty;
    tag = key[7:0] & MetaTagMask;
    grp = 32'(key % GroupCount);
    for (int p = 0; p < MaxProbes; p++) begin
      seen_empty = 1'b0;
      for (int lane = 0; lane < GroupSize; lane++) begin
        int s;
        s = grp * GroupSize + lane;
        if (shadow_meta[s] == tag && shadow_hash[s] == key) return s;
        if (shadow_meta[s] == MetaEmpty) seen_empty = 1'b1;
      end
      if (seen_empty) return -1;
      grp = (grp + ((p + 1) * (p + 1)) % GroupCount) % GroupCount;
    end
    return -1;
  endfunction

  // Claim a slot for the key; return 0 if every probed group was full.
  function automatic bit claim_slot(input logic [63:0] key,
                                    input logic [TargetWidth-1:0] tgt);
    int unsigned grp;
    int          pick;
    grp = 32'(key % GroupCount);
    for (int p = 0; p < MaxProbes; p++) begin
      pick = -1;
      for (int lane = 0; lane < GroupSize && pick < 0; lane++)
        if (shadow_meta[grp * GroupSize + lane] == MetaEmpty) pick = grp * GroupSize + lane;
      for (int lane = 0; lane < GroupSize && pick < 0; lane++)
        if (shadow_meta[grp * GroupSize + lane] == MetaDead) pick = grp * GroupSize + lane;
      if (pick >= 0) begin
        shadow_hash[pick] = key;
        shadow_tgt[pick]  = tgt;
        shadow_meta[pick] = key[7:0] & MetaTagMask;
        return 1'b1;
      end
      grp = (grp + ((p + 1) * (p + 1)) % GroupCount) % GroupCount;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t predict_lookup(input in_item_t item);
    out_item_t res;
    int        s;
    res = '0;
    s = locate_key(item.key_hash);
    if (!item.opcode) begin
      if (s >= 0) begin
        res.status     = ST_FOUND;
        res.target_out = 16'(shadow_tgt[s]);
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end else if (s >= 0) begin
      res.status = ST_DUPLICATE;
    end else if (claim_slot(item.key_hash, item.target_in[TargetWidth-1:0])) begin
      res.status = ST_INSERTED;
      stored_keys.push_back(item.key_hash);
    end else begin
      res.status = ST_FULL;
    end
    return res;
  endfunction

  // Send one item: hold valid and payload until accepted, predict at accept.
  // Drop valid only while idling, so each falling edge sees one update.
  task automatic send_item(input logic op, input logic [63:0] key,
                           input logic [15:0] tgt);
    in_item_t item;
    while (idle_enable && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    item.opcode    = op;
    item.key_hash  = key;
    item.target_in = tgt;
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_lookup(item));
    @(negedge clk_i);
  endtask

  // Output side: stall at random, check every accepted result item.
  always @(negedge clk_i)
    if (rst_ni) out_ready_i <= !(idle_enable && $urandom_range(99) < 18);

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result status", 32'(out_item_o.status), 32'(0));
      end else begin
        want = pending_results.pop_front();
        if (want.status == ST_FULL) full_count++;
        if (want.status == ST_FOUND) found_count++;
        if (out_item_o.status != want.status)
          report_mismatch("status", 32'(out_item_o.status), 32'(want.status));
        if (out_item_o.target_out != want.target_out)
          report_mismatch("target_out", 32'(out_item_o.target_out), 32'(want.target_out));
      end
    end
  end

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Key with a chosen home group and random upper bits.
  function automatic logic [63:0] key_in_group(input int unsigned grp);
    logic [63:0] k;
    k = rand_key();
    k[GroupW-1:0] = GroupW'(grp);
    return k;
  endfunction

  // Extremes of the fields, find on an empty table, duplicate, tag collision.
  task automatic test_directed();
    logic [63:0] k;
    send_item(1'b0, 64'h0, 16'h0);
    send_item(1'b1, 64'h0, 16'hFFFF);
    send_item(1'b0, 64'h0, 16'h1234);
    send_item(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
    send_item(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    send_item(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 16'h5A5A);
    send_item(1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA);
    send_item(1'b1, 64'h5555_5555_5555_5555, 16'h5555);
    // same tag and group, different upper hash bits
    send_item(1'b1, 64'h8000_0000_0000_0000, 16'h0001);
    send_item(1'b0, 64'h8000_0000_0000_0000, 16'h0);
    send_item(1'b0, 64'h4000_0000_0000_0000, 16'h0);
    send_item(1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 16'h0);
    send_item(1'b0, 64'h5555_5555_5555_5555, 16'h0);
    k = rand_key();
    send_item(1'b0, k, 16'h0);
  endtask

  // Overfill one group so probing spills to later groups, then look back.
  task automatic test_group_overflow();
    logic [63:0] keys[$];
    for (int i = 0; i < 3 * GroupSize; i++) begin
      keys.push_back(key_in_group(5));
      send_item(1'b1, keys[i], 16'($urandom()));
    end
    foreach (keys[i]) send_item(1'b0, keys[i], 16'h0);
  endtask

  // Mixed random traffic of finds and sets; about 45 percent reuse a stored key.
  task automatic test_random_mix(input int unsigned count);
    int unsigned pick;
    logic [63:0] k;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (stored_keys.size() > 0 && pick < 45)
        k = stored_keys[$urandom_range(stored_keys.size() - 1)];
      else if (pick < 60)
        k = key_in_group($urandom_range(3));
      else
        k = rand_key();
      send_item(1'($urandom()), k, 16'($urandom()));
      if (i == count / 2) idle_enable = 1'b0;
      if (i == count / 2 + 200) idle_enable = 1'b1;
    end
  endtask

  // Fill the whole table so sets hit the probe cap and answer full.
  task automatic test_table_full();
    int unsigned tries;
    tries = 0;
    while (full_count < 40 && tries < SlotTotal + 400) begin
      send_item(1'b1, rand_key(), 16'($urandom()));
      tries++;
    end
    for (int i = 0; i < 40; i++) send_item(1'b0, rand_key(), 16'h0);
    for (int i = 0; i < 40; i++)
      send_item(1'b0, stored_keys[$urandom_range(stored_keys.size() - 1)], 16'h0);
  endtask

  initial begin
    for (int s = 0; s < SlotTotal; s++) begin
      shadow_meta[s] = MetaEmpty;
      shadow_hash[s] = '0;
      shadow_tgt[s]  = '0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_group_overflow();
    test_random_mix(RandItems);
    test_table_full();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d results, %0d found, %0d table-full answers, %0d keys stored",
             result_count, found_count, full_count, stored_keys.size());
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Full-table sets probe 64 groups twice, once in the find and once in the insert search.
  initial begin
    #20_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
